@@ hdl/bpmc_pkg.sv @@
// types and constants shared by the battery power mode classifier
package bpmc_pkg;

  localparam int unsigned ALPHA_BITS  = 16;
  localparam int unsigned ALPHA_SHIFT = 15;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 16'd32768;

  localparam int unsigned CFG_INDEX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_SMOOTHING_ALPHA = 3'd0,
    REG_DOWN_SAFE_MV    = 3'd1,
    REG_DOWN_CRUISE_MV  = 3'd2,
    REG_DOWN_FULL_MV    = 3'd3,
    REG_UP_SAFE_MV      = 3'd4,
    REG_UP_CRUISE_MV    = 3'd5,
    REG_UP_FULL_MV      = 3'd6
  } reg_index_t;

  typedef enum logic [2:0] {
    MODE_NONE     = 3'd0,
    MODE_CRITICAL = 3'd1,
    MODE_SAFE     = 3'd2,
    MODE_CRUISE   = 3'd3,
    MODE_FULL     = 3'd4
  } mode_t;

  localparam logic KIND_CONDITION = 1'b0;
  localparam logic KIND_PRIME     = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] battery_mv;
  } in_item_t;

  typedef struct packed {
    mode_t       mode_request;
    logic [15:0] filtered_mv;
  } out_item_t;

endpackage

@@ hdl/battery_power_mode_classifier.sv @@
// battery power mode classifier: smoothing filter with hysteresis thresholds
//
// input channel in_valid / in_stall / in_data carries one voltage request: a
// condition sample (kind 0) or a prime of the stored average (kind 1).
// output channel out_valid / out_stall / out_data returns exactly one result
// per request: the requested mode and the filtered voltage, in request order.
// a request is taken into an input register, passes the combinational filter
// multiply-add and threshold compare, and lands in the result register once
// that register is empty or not stalled, and then shows on out_valid.
// one request per cycle without stalls; the stored average is updated on the
// same edge that loads the result, so the next request already sees it.
// when the receiver stalls, the result holds; the input register fills and
// in_stall rises only when both registers are occupied.
// reset (rst, synchronous) empties both registers, clears the stored
// average and restores the threshold and alpha defaults.
// configuration is written through cfg_write / cfg_index / cfg_data by the user only while no
// request is in flight (the block does not enforce this); indexes beyond the register list are ignored.
module battery_power_mode_classifier
  import bpmc_pkg::*;
#(
  parameter int unsigned VOLT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_write,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int unsigned ACC_BITS = VOLT_BITS + ALPHA_BITS;
  localparam int unsigned CMP_BITS = (VOLT_BITS > 16) ? VOLT_BITS : 16;

  logic [15:0] smoothing_alpha;
  logic [15:0] down_safe_mv;
  logic [15:0] down_cruise_mv;
  logic [15:0] down_full_mv;
  logic [15:0] up_safe_mv;
  logic [15:0] up_cruise_mv;
  logic [15:0] up_full_mv;

  logic [VOLT_BITS-1:0] average_mv;
  logic [VOLT_BITS-1:0] average_mv_next;

  logic     s_valid;
  in_item_t s_item;
  logic     move;

  logic [VOLT_BITS+15:0] x_wide;
  logic [VOLT_BITS-1:0]  x_v;
  logic [ALPHA_BITS-1:0] alpha_sat;
  logic [ALPHA_BITS-1:0] alpha_rest;
  logic [ACC_BITS-1:0]   acc;
  logic [VOLT_BITS-1:0]  y_v;
  logic [VOLT_BITS+15:0] y_wide;
  logic [CMP_BITS-1:0]   y_c;
  logic                  falling;
  mode_t                 mode;
  out_item_t             result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_alpha <= 16'd16384;
      down_safe_mv    <= 16'd6600;
      down_cruise_mv  <= 16'd7000;
      down_full_mv    <= 16'd7400;
      up_safe_mv      <= 16'd6800;
      up_cruise_mv    <= 16'd7200;
      up_full_mv      <= 16'd7600;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SMOOTHING_ALPHA: smoothing_alpha <= cfg_data;
        REG_DOWN_SAFE_MV:    down_safe_mv    <= cfg_data;
        REG_DOWN_CRUISE_MV:  down_cruise_mv  <= cfg_data;
        REG_DOWN_FULL_MV:    down_full_mv    <= cfg_data;
        REG_UP_SAFE_MV:      up_safe_mv      <= cfg_data;
        REG_UP_CRUISE_MV:    up_cruise_mv    <= cfg_data;
        REG_UP_FULL_MV:      up_full_mv      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign move     = s_valid && (!out_valid || !out_stall);
  assign in_stall = s_valid && !move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s_valid <= 1'b1;
    end else if (move) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s_item <= in_data;
    end
  end

  // sample fitted to the voltage width
  assign x_wide = {{VOLT_BITS{1'b0}}, s_item.battery_mv};
  assign x_v    = x_wide[VOLT_BITS-1:0];

  assign alpha_sat  = (smoothing_alpha > ALPHA_ONE) ? ALPHA_ONE : smoothing_alpha;
  assign alpha_rest = ALPHA_ONE - alpha_sat;

  assign acc = ACC_BITS'(alpha_sat) * ACC_BITS'(x_v)
             + ACC_BITS'(alpha_rest) * ACC_BITS'(average_mv);

  always_comb begin
    if (s_item.kind == KIND_PRIME) begin
      y_v = x_v;
    end else begin
      y_v = acc[VOLT_BITS+ALPHA_SHIFT-1:ALPHA_SHIFT];
    end
  end

  assign y_wide  = {16'd0, y_v};
  assign y_c     = CMP_BITS'(y_v);
  assign falling = (s_item.kind == KIND_CONDITION) && (y_v < average_mv);

  // threshold chains
  always_comb begin
    mode            = MODE_NONE;
    average_mv_next = average_mv;
    if (s_item.kind == KIND_PRIME) begin
      average_mv_next = x_v;
    end else if (falling) begin
      priority if (y_c < CMP_BITS'(down_safe_mv))   mode = MODE_CRITICAL;
      else if (y_c < CMP_BITS'(down_cruise_mv))     mode = MODE_SAFE;
      else if (y_c < CMP_BITS'(down_full_mv))       mode = MODE_CRUISE;
      else if (y_c > CMP_BITS'(up_full_mv))         mode = MODE_FULL;
      else                                          mode = MODE_NONE;
    end else begin
      average_mv_next = y_v;
      priority if (y_c > CMP_BITS'(up_full_mv))     mode = MODE_FULL;
      else if (y_c > CMP_BITS'(up_cruise_mv))       mode = MODE_CRUISE;
      else if (y_c > CMP_BITS'(up_safe_mv))         mode = MODE_SAFE;
      else                                          mode = MODE_NONE;
    end
  end

  assign result.mode_request = mode;
  assign result.filtered_mv  = y_wide[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      average_mv <= '0;
    end else if (move) begin
      average_mv <= average_mv_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_data <= result;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s_valid && out_valid && out_stall))
    else $error("input stalled while a register is free");

  a_prime_loads_average: assert property (@(posedge clk) disable iff (rst)
    (move && s_item.kind == KIND_PRIME) |=> (average_mv == $past(x_v)))
    else $error("prime did not load the stored average");

  a_falling_keeps_average: assert property (@(posedge clk) disable iff (rst)
    (move && falling) |=> $stable(average_mv))
    else $error("falling sample changed the stored average");

  a_prime_gives_none: assert property (@(posedge clk) disable iff (rst)
    (move && s_item.kind == KIND_PRIME) |=> (out_valid && out_data.mode_request == MODE_NONE))
    else $error("prime result requested a mode");

endmodule

@@ dv/battery_power_mode_classifier_tb.sv @@
// self-checking testbench for the battery power mode classifier
`timescale 1ns / 100ps

module battery_power_mode_classifier_tb;
  import bpmc_pkg::*;

  localparam int ITEMS_PER_PHASE = 130;
  localparam int LONG_HOLD       = 60;
  localparam int CYCLE_LIMIT     = 300000;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_INDEX_SPARE = 3'd7;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  battery_power_mode_classifier DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  in_item_t  pending_requests[$];
  out_item_t expected_results[$];

  // shadow of the register file and the stored average
  logic [15:0] reg_shadow [0:6];
  logic [15:0] stored_avg;

  int  cycle_count, items_queued, items_taken, primes_taken;
  int  results_checked, mismatches, settings_used;
  bit  req_taken;
  bit  quiet;
  int  send_gap, stall_left, hold_left;
  int  hold_asks, hold_seen;

  initial begin
    forever #5 clk = ~clk;
  end

  // filter the sample, pick the mode and update the stored average
  function automatic out_item_t classify_request(in_item_t req);
    out_item_t       res;
    longint unsigned weight, one_q, acc;
    logic [15:0]     y;
    one_q  = ALPHA_ONE;
    weight = (reg_shadow[REG_SMOOTHING_ALPHA] > ALPHA_ONE) ? ALPHA_ONE
             : reg_shadow[REG_SMOOTHING_ALPHA];
    if (req.kind == KIND_PRIME) begin
      stored_avg       = req.battery_mv;
      res.mode_request = MODE_NONE;
      res.filtered_mv  = req.battery_mv;
    end else begin
      acc = weight * req.battery_mv + (one_q - weight) * stored_avg;
      y   = 16'(acc >> ALPHA_SHIFT);
      if (y < stored_avg) begin
        // falling: average kept, full still possible above up_full
        if (y < reg_shadow[REG_DOWN_SAFE_MV])        res.mode_request = MODE_CRITICAL;
        else if (y < reg_shadow[REG_DOWN_CRUISE_MV]) res.mode_request = MODE_SAFE;
        else if (y < reg_shadow[REG_DOWN_FULL_MV])   res.mode_request = MODE_CRUISE;
        else if (y > reg_shadow[REG_UP_FULL_MV])     res.mode_request = MODE_FULL;
        else                                         res.mode_request = MODE_NONE;
      end else begin
        if (y > reg_shadow[REG_UP_FULL_MV])          res.mode_request = MODE_FULL;
        else if (y > reg_shadow[REG_UP_CRUISE_MV])   res.mode_request = MODE_CRUISE;
        else if (y > reg_shadow[REG_UP_SAFE_MV])     res.mode_request = MODE_SAFE;
        else                                         res.mode_request = MODE_NONE;
        stored_avg = y;
      end
      res.filtered_mv = y;
    end
    return res;
  endfunction

  function automatic in_item_t random_request();
    in_item_t    req;
    int unsigned pick;
    pick     = $urandom_range(0, 9);
    req.kind = ($urandom_range(0, 7) == 0) ? KIND_PRIME : KIND_CONDITION;
    if (pick < 2)       req.battery_mv = 16'($urandom_range(0, 65535));
    else if (pick == 2) req.battery_mv = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    else                req.battery_mv = 16'($urandom_range(5800, 8200));
    return req;
  endfunction

  task automatic queue_request(logic kind, logic [15:0] mv);
    in_item_t req;
    req.kind       = kind;
    req.battery_mv = mv;
    pending_requests.push_back(req);
    items_queued++;
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    // indexes past the list are dropped by the block
    if (idx <= REG_UP_FULL_MV) reg_shadow[idx] = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic program_regs(logic [15:0] alpha, logic [15:0] ds, logic [15:0] dc,
                              logic [15:0] df, logic [15:0] us, logic [15:0] uc,
                              logic [15:0] uf);
    write_reg(REG_SMOOTHING_ALPHA, alpha);
    write_reg(REG_DOWN_SAFE_MV, ds);
    write_reg(REG_DOWN_CRUISE_MV, dc);
    write_reg(REG_DOWN_FULL_MV, df);
    write_reg(REG_UP_SAFE_MV, us);
    write_reg(REG_UP_CRUISE_MV, uc);
    write_reg(REG_UP_FULL_MV, uf);
    settings_used++;
  endtask

  // the test sequence stops here until every request has come back
  task automatic wait_idle();
    while (items_taken != items_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(int count, bit long_hold);
    in_item_t req;
    repeat (count) begin
      req = random_request();
      queue_request(req.kind, req.battery_mv);
    end
    if (long_hold) hold_asks++;
    wait_idle();
  endtask

  // sender
  always @(negedge clk) begin
    if (in_valid && !req_taken) begin
      // held until taken
    end else if (send_gap > 0) begin
      send_gap--;
      in_valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      send_gap = $urandom_range(1, 9) - 1;
      in_valid <= 1'b0;
    end else if (!rst && pending_requests.size() != 0) begin
      in_valid <= 1'b1;
      in_data  <= pending_requests.pop_front();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // acceptance, prediction and result check
  always @(posedge clk) begin
    out_item_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end else if (rst) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        expected_results.push_back(classify_request(in_data));
        items_taken++;
        if (in_data.kind == KIND_PRIME) primes_taken++;
      end
      if (out_valid && !out_stall) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, mode_request %0d filtered_mv %0d",
                   $time, out_data.mode_request, out_data.filtered_mv);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_data.mode_request !== want.mode_request) begin
            $display("%0t: mode_request expected %0d actual %0d", $time,
                     want.mode_request, out_data.mode_request);
            mismatches++;
          end
          if (out_data.filtered_mv !== want.filtered_mv) begin
            $display("%0t: filtered_mv expected %0d actual %0d", $time,
                     want.filtered_mv, out_data.filtered_mv);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    reg_shadow[REG_SMOOTHING_ALPHA] = 16'd16384;
    reg_shadow[REG_DOWN_SAFE_MV]    = 16'd6600;
    reg_shadow[REG_DOWN_CRUISE_MV]  = 16'd7000;
    reg_shadow[REG_DOWN_FULL_MV]    = 16'd7400;
    reg_shadow[REG_UP_SAFE_MV]      = 16'd6800;
    reg_shadow[REG_UP_CRUISE_MV]    = 16'd7200;
    reg_shadow[REG_UP_FULL_MV]      = 16'd7600;
    stored_avg    = '0;
    settings_used = 1;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, both chains, threshold boundaries
    queue_request(KIND_PRIME, 16'd0);
    queue_request(KIND_CONDITION, 16'hFFFF);
    queue_request(KIND_CONDITION, 16'd0);     // falling but still above up_full
    queue_request(KIND_PRIME, 16'd7000);
    queue_request(KIND_CONDITION, 16'd6000);
    queue_request(KIND_CONDITION, 16'd6900);
    queue_request(KIND_CONDITION, 16'd7700);
    queue_request(KIND_CONDITION, 16'd7350);  // equal to average takes the rising chain
    queue_request(KIND_CONDITION, 16'd7000);
    queue_request(KIND_CONDITION, 16'd8000);
    queue_request(KIND_PRIME, 16'd6800);
    queue_request(KIND_CONDITION, 16'd6800);
    queue_request(KIND_CONDITION, 16'd6801);
    queue_request(KIND_CONDITION, 16'd6802);
    queue_request(KIND_PRIME, 16'hFFFF);
    queue_request(KIND_CONDITION, 16'hFFFF);
    queue_request(KIND_CONDITION, 16'hFFFE);
    queue_request(KIND_PRIME, 16'd7400);
    queue_request(KIND_CONDITION, 16'd7398);
    queue_request(KIND_CONDITION, 16'd7400);
    queue_request(KIND_PRIME, 16'h5555);
    queue_request(KIND_CONDITION, 16'hAAAA);
    wait_idle();

    // defaults, with one long receiver hold so the input backs up
    run_random(ITEMS_PER_PHASE, 1'b1);

    // alpha of one: output follows the sample
    program_regs(ALPHA_ONE, 16'd6600, 16'd7000, 16'd7400, 16'd6800, 16'd7200, 16'd7600);
    run_random(ITEMS_PER_PHASE, 1'b0);

    // alpha above one saturates; extreme thresholds; spare index ignored
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    write_reg(CFG_INDEX_SPARE, 16'h0000);
    run_random(ITEMS_PER_PHASE, 1'b0);

    // alpha of zero: average only moves on primes
    program_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(ITEMS_PER_PHASE, 1'b0);

    // thresholds in reversed order
    program_regs(16'd1, 16'd7400, 16'd7000, 16'd6600, 16'd7600, 16'd7200, 16'd6800);
    run_random(ITEMS_PER_PHASE, 1'b0);

    program_regs(16'($urandom_range(0, 32768)), 16'($urandom_range(5800, 8200)),
                 16'($urandom_range(5800, 8200)), 16'($urandom_range(5800, 8200)),
                 16'($urandom_range(5800, 8200)), 16'($urandom_range(5800, 8200)),
                 16'($urandom_range(5800, 8200)));
    run_random(ITEMS_PER_PHASE, 1'b0);

    // back to defaults, full rate on both sides
    program_regs(16'd16384, 16'd6600, 16'd7000, 16'd7400, 16'd6800, 16'd7200, 16'd7600);
    quiet = 1'b1;
    run_random(ITEMS_PER_PHASE, 1'b0);

    repeat (10) @(negedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
      mismatches += expected_results.size();
    end
    $display("run covered %0d requests (%0d primes) across %0d register settings",
             items_taken, primes_taken, settings_used);
    $display("%0d results checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
